/* rtl/skvt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

   // Table geometry
   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;
   localparam int FUNC_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Command queue between front and engine
   localparam int FQ_DEPTH   = 2;
   localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W   = $clog2(FQ_DEPTH + 1);

   typedef enum logic [FUNC_W-1:0] {
      FN_PUT      = 3'd0,
      FN_GET      = 3'd1,
      FN_CONTAINS = 3'd2,
      FN_REMOVE   = 3'd3,
      FN_FIRST    = 3'd4,
      FN_NEXT     = 3'd5,
      FN_CLEAR    = 3'd6,
      FN_UNUSED   = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_ITER   = 2'd3
   } status_type;

   // Classified command word handed from front to engine
   typedef struct packed {
      func_type                func;
      logic                    search;     // needs a walk over the keys
      logic                    drop_iter;  // invalidates the iterator
      logic [KEY_BITS-1:0]     key;
      logic [VALUE_BITS-1:0]   value;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/skvt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module skvt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [skvt_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [skvt_pkg::KEY_BITS-1:0] req_key,
   input  wire logic [skvt_pkg::VALUE_BITS-1:0] req_value,
   output skvt_pkg::cmd_type                  cmd,
   output logic                               cmd_avail,
   input  wire logic                          cmd_pop
);
   import skvt_pkg::*;

   cmd_type               fq_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   cmd_type               cls;
   logic                  push_ok;
   logic                  pop_ok;

   // Classify the incoming word
   always_comb begin
      cls.func  = func_type'(req_func);
      cls.key   = req_key;
      cls.value = req_value;
      unique case (cls.func) inside
         FN_PUT, FN_REMOVE:  begin cls.search = 1'b1; cls.drop_iter = 1'b1; end
         FN_CONTAINS:        begin cls.search = 1'b1; cls.drop_iter = 1'b1; end
         FN_GET:             begin cls.search = 1'b1; cls.drop_iter = 1'b0; end
         FN_CLEAR:           begin cls.search = 1'b0; cls.drop_iter = 1'b1; end
         default:            begin cls.search = 1'b0; cls.drop_iter = 1'b0; end
      endcase
   end

   assign req_full  = (cnt_ff == FQ_CNT_W'(FQ_DEPTH));
   assign cmd_avail = (cnt_ff != '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_avail;
   assign cmd       = fq_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         fq_ff[wr_ptr_ff] <= cls;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FQ_CNT_W'(FQ_DEPTH))
      else $error("command queue over capacity");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == FQ_CNT_W'(FQ_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers out of step");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_avail)
      else $error("engine took a word from an empty queue");

endmodule

`default_nettype wire

/* rtl/skvt_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module skvt_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire skvt_pkg::cmd_type               cmd,
   input  wire logic                            cmd_avail,
   output logic                                 cmd_pop,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic [skvt_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_found,
   output logic [skvt_pkg::KEY_BITS-1:0]        rsp_out_key,
   output logic [skvt_pkg::VALUE_BITS-1:0]      rsp_out_value,
   output logic [skvt_pkg::CNT_W-1:0]           rsp_entry_count
);
   import skvt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SHUP = 4'b0100,
      S_SHDN = 4'b1000
   } state_type;

   // Entry storage, undefined until written
   logic [KEY_BITS-1:0]   keys_ff [CAPACITY];
   logic [VALUE_BITS-1:0] vals_ff [CAPACITY];

   state_type             state_ff, state_in;
   cmd_type               op_ff, op_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [IDX_W-1:0]      shift_ff, shift_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      iter_pos_ff, iter_pos_in;
   logic                  iter_valid_ff, iter_valid_in;

   logic                  res_valid_ff, res_valid_in;
   status_type            res_status_ff, res_status_in;
   logic                  res_found_ff, res_found_in;
   logic [KEY_BITS-1:0]   res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0] res_value_ff, res_value_in;

   logic [IDX_W-1:0]      rd_idx;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;
   logic                  in_range;
   logic                  key_match;

   // Single read port, one address per cycle
   always_comb begin
      rd_idx = scan_ff[IDX_W-1:0];
      unique case (state_ff)
         S_EXEC: begin
            case (op_ff.func)
               FN_FIRST: rd_idx = '0;
               FN_NEXT:  rd_idx = iter_pos_ff + 1'b1;
               default:  rd_idx = scan_ff[IDX_W-1:0];
            endcase
         end
         S_SHUP:  rd_idx = shift_ff - 1'b1;
         S_SHDN:  rd_idx = shift_ff + 1'b1;
         default: rd_idx = scan_ff[IDX_W-1:0];
      endcase
   end

   assign rd_key    = keys_ff[rd_idx];
   assign rd_value  = vals_ff[rd_idx];
   assign in_range  = (scan_ff < count_ff);
   assign key_match = in_range && (rd_key == op_ff.key);

   // Sequencer: walk, then shift where needed, then post the result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      scan_in       = scan_ff;
      shift_in      = shift_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      iter_pos_in   = iter_pos_ff;
      iter_valid_in = iter_valid_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_key_in    = res_key_ff;
      res_value_in  = res_value_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = shift_ff;
      wr_key        = rd_key;
      wr_value      = rd_value;

      if (rsp_pop && res_valid_ff) begin
         res_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Start only with the result slot free, so it is never overwritten
            if (cmd_avail && !res_valid_in) begin
               cmd_pop       = 1'b1;
               op_in         = cmd;
               scan_in       = '0;
               res_status_in = ST_OK;
               res_found_in  = 1'b0;
               res_key_in    = '0;
               res_value_in  = '0;
               if (cmd.drop_iter) begin
                  iter_valid_in = 1'b0;
               end
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (op_ff.search && in_range && (rd_key < op_ff.key)) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               res_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (op_ff.func)
                  FN_PUT: begin
                     if (key_match) begin
                        wr_en        = 1'b1;
                        wr_idx       = scan_ff[IDX_W-1:0];
                        wr_key       = op_ff.key;
                        wr_value     = op_ff.value;
                        res_found_in = 1'b1;
                        res_value_in = op_ff.value;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else if (scan_ff == count_ff) begin
                        // Append at the top end
                        wr_en    = 1'b1;
                        wr_idx   = scan_ff[IDX_W-1:0];
                        wr_key   = op_ff.key;
                        wr_value = op_ff.value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        res_valid_in = 1'b0;
                        shift_in     = count_ff[IDX_W-1:0];
                        pos_in       = scan_ff[IDX_W-1:0];
                        state_in     = S_SHUP;
                     end
                  end
                  FN_GET, FN_CONTAINS: begin
                     if (key_match) begin
                        res_found_in = 1'b1;
                        res_value_in = rd_value;
                     end else begin
                        res_status_in = ST_MISS;
                     end
                  end
                  FN_REMOVE: begin
                     if (key_match) begin
                        res_found_in = 1'b1;
                        res_value_in = rd_value;
                        res_valid_in = 1'b0;
                        shift_in     = scan_ff[IDX_W-1:0];
                        state_in     = S_SHDN;
                     end else begin
                        res_status_in = ST_MISS;
                     end
                  end
                  FN_FIRST: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_MISS;
                     end else begin
                        iter_valid_in = 1'b1;
                        iter_pos_in   = '0;
                        res_found_in  = 1'b1;
                        res_key_in    = rd_key;
                        res_value_in  = rd_value;
                     end
                  end
                  FN_NEXT: begin
                     if (!iter_valid_ff) begin
                        res_status_in = ST_ITER;
                     end else if (CNT_W'(iter_pos_ff) + CNT_W'(1) >= count_ff) begin
                        iter_valid_in = 1'b0;
                        res_status_in = ST_MISS;
                     end else begin
                        iter_pos_in  = iter_pos_ff + 1'b1;
                        res_found_in = 1'b1;
                        res_key_in   = rd_key;
                        res_value_in = rd_value;
                     end
                  end
                  FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Open a hole at the insert point, top entry first
         S_SHUP: begin
            wr_en = 1'b1;
            if (shift_ff == pos_ff) begin
               wr_key       = op_ff.key;
               wr_value     = op_ff.value;
               count_in     = count_ff + 1'b1;
               res_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               shift_in = shift_ff - 1'b1;
            end
         end

         // Close the gap left by a removed entry
         S_SHDN: begin
            if (CNT_W'(shift_ff) + CNT_W'(1) < count_ff) begin
               wr_en    = 1'b1;
               shift_in = shift_ff + 1'b1;
            end else begin
               count_in     = count_ff - 1'b1;
               res_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         iter_pos_ff   <= '0;
         iter_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         iter_pos_ff   <= iter_pos_in;
         iter_valid_ff <= iter_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   // Working and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      scan_ff       <= scan_in;
      shift_ff      <= shift_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_key_ff    <= res_key_in;
      res_value_ff  <= res_value_in;
   end

   // Entry write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_ff[wr_idx] <= wr_key;
         vals_ff[wr_idx] <= wr_value;
      end
   end

   assign rsp_empty       = !res_valid_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_found       = res_found_ff;
   assign rsp_out_key     = res_key_ff;
   assign rsp_out_value   = res_value_ff;
   assign rsp_entry_count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_iter_in_table: assert property (@(posedge clock) disable iff (reset)
      iter_valid_ff |-> (CNT_W'(iter_pos_ff) < count_ff))
      else $error("iterator points past the last entry");

   a_busy_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !res_valid_ff)
      else $error("engine busy while a result word is still waiting");

   a_shift_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHUP) |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("insert shift started on a full table");

endmodule

`default_nettype wire

/* rtl/sorted_key_value_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table of skvt_pkg::CAPACITY entries held in ascending key
// order. A word is pushed with func, key and value; exactly one result word
// comes back per pushed word, in order. Pushed words wait in a two-deep
// command queue while the engine works. The engine walks the stored keys one
// entry a cycle and moves entries one a cycle through its single read port.
// The walk stops at the insert or match point and the shift covers only the
// entries above it. Get and contains walk but do not shift; first, next and
// clear neither walk nor shift. Each word is picked up from the queue before
// its walk begins. The engine starts the next word only once the previous
// result has been popped. Entries above the entry count are never used, so
// the storage needs no clearing after reset.

module sorted_key_value_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [skvt_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [skvt_pkg::KEY_BITS-1:0]     req_key,
   input  wire logic [skvt_pkg::VALUE_BITS-1:0]   req_value,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [skvt_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_found,
   output logic [skvt_pkg::KEY_BITS-1:0]          rsp_out_key,
   output logic [skvt_pkg::VALUE_BITS-1:0]        rsp_out_value,
   output logic [skvt_pkg::CNT_W-1:0]             rsp_entry_count
);
   import skvt_pkg::*;

   cmd_type cmd;
   logic    cmd_avail;
   logic    cmd_pop;

   // Accept and classify
   skvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_func  (req_func),
      .req_key   (req_key),
      .req_value (req_value),
      .cmd       (cmd),
      .cmd_avail (cmd_avail),
      .cmd_pop   (cmd_pop)
   );

   // Search, shift and report
   skvt_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cmd_avail       (cmd_avail),
      .cmd_pop         (cmd_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

`default_nettype wire
